// ===== hdl/srp_pkg.sv =====
`timescale 1ns / 1ps

package srp_pkg;

	localparam int SPEED_BITS_DEF = 17;

	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = 32;

	localparam int CLK_BITS      = 32;
	localparam int STEP_BITS     = 16;
	localparam int USTEP_BITS    = 3;
	localparam int STEP_DIV_BITS = STEP_BITS + (1 << USTEP_BITS) - 1;
	localparam int MUL_SHIFT     = 10;
	localparam int PROD_BITS     = CLK_BITS + MUL_SHIFT;
	localparam int ITER_BITS     = $clog2(PROD_BITS + 1);

	localparam logic [MUL_SHIFT-1:0] MUL_K      = MUL_SHIFT'(1000);
	localparam logic [ITER_BITS-1:0] DIV1_ITERS = ITER_BITS'(CLK_BITS);
	localparam logic [ITER_BITS-1:0] DIV2_ITERS = ITER_BITS'(PROD_BITS);

	localparam logic [15:0]          MAX_SPEED_RST = 16'hFFFF;
	localparam logic [15:0]          MAX_DELTA_RST = 16'd1;
	localparam logic [CLK_BITS-1:0]  CLK_X30_RST   = 32'd2160000000;
	localparam logic [STEP_BITS-1:0] STEPS_RST     = 16'd200;

	typedef enum logic [1:0] {
		ACT_SET   = 2'd0,
		ACT_TICK  = 2'd1,
		ACT_START = 2'd2,
		ACT_STOP  = 2'd3
	} action_t;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		CFG_MAX_SPEED = 3'd0,
		CFG_MAX_DELTA = 3'd1,
		CFG_REVERSE   = 3'd2,
		CFG_USTEP     = 3'd3,
		CFG_CLK_X30   = 3'd4,
		CFG_STEPS     = 3'd5
	} cfg_idx_t;

endpackage

// ===== hdl/srp_in_if.sv =====
`timescale 1ns / 1ps

interface srp_in_if #(
	parameter int SPEED_BITS = srp_pkg::SPEED_BITS_DEF
);
	logic                         valid;
	logic                         ready;
	logic [1:0]                   action;
	logic signed [SPEED_BITS-1:0] target_in;

	modport source (output valid, output action, output target_in, input ready);
	modport sink   (input valid, input action, input target_in, output ready);
endinterface

// ===== hdl/srp_out_if.sv =====
`timescale 1ns / 1ps

interface srp_out_if #(
	parameter int SPEED_BITS = srp_pkg::SPEED_BITS_DEF
);
	logic                               valid;
	logic                               ready;
	logic signed [SPEED_BITS-1:0]       speed_now;
	logic                               dir_pin;
	logic [srp_pkg::CLK_BITS-1:0]       step_period;
	logic                               period_load;
	logic                               enable_n;
	logic                               running;

	modport source (output valid, output speed_now, output dir_pin, output step_period,
		output period_load, output enable_n, output running, input ready);
	modport sink   (input valid, input speed_now, input dir_pin, input step_period,
		input period_load, input enable_n, input running, output ready);
endinterface

// ===== hdl/srp_div.sv =====
`timescale 1ns / 1ps

// restoring divider, one quotient bit per cycle
module srp_div #(
	parameter int N = srp_pkg::PROD_BITS,
	parameter int D = srp_pkg::STEP_DIV_BITS
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       go,
	input  logic [N-1:0]               dividend,
	input  logic [D-1:0]               divisor,
	input  logic [$clog2(N+1)-1:0]     iters,
	output logic                       done,
	output logic [N-1:0]               quo
);
	logic [D-1:0]           rem_q;
	logic [N-1:0]           dq_q;
	logic [D-1:0]           dv_q;
	logic [$clog2(N+1)-1:0] cnt_q;
	logic                   busy_q;
	logic                   done_q;

	logic [D:0] sh;
	logic [D:0] diff;
	logic       ge;

	assign sh   = {rem_q, dq_q[N-1]};
	assign diff = sh - {1'b0, dv_q};
	assign ge   = (sh >= {1'b0, dv_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= '0;
			dq_q   <= '0;
			dv_q   <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				rem_q  <= '0;
				dq_q   <= dividend;
				dv_q   <= divisor;
				cnt_q  <= iters;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				rem_q <= ge ? diff[D-1:0] : sh[D-1:0];
				dq_q  <= {dq_q[N-2:0], ge};
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == ($clog2(N+1))'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign quo  = dq_q;
endmodule

// ===== hdl/srp_period.sv =====
`timescale 1ns / 1ps

// period = sat32((clock_x30 / (steps << ustep)) * 1000 / mag)
module srp_period #(
	parameter int SPEED_BITS = srp_pkg::SPEED_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic [SPEED_BITS-2:0]               mag,
	input  logic [srp_pkg::CLK_BITS-1:0]        clock_x30,
	input  logic [srp_pkg::STEP_BITS-1:0]       steps_per_rev,
	input  logic [srp_pkg::USTEP_BITS-1:0]      microstep_shift,
	output logic                                done,
	output logic [srp_pkg::CLK_BITS-1:0]        period
);
	localparam int PB = srp_pkg::PROD_BITS;
	localparam int CB = srp_pkg::CLK_BITS;
	localparam int D  = (SPEED_BITS - 1 > srp_pkg::STEP_DIV_BITS) ?
		SPEED_BITS - 1 : srp_pkg::STEP_DIV_BITS;

	typedef enum logic [2:0] {S_IDLE, S_DIV1, S_MUL, S_DIV2} pstate_t;

	pstate_t               st_q;
	logic                  go_q;
	logic                  sel2_q;
	logic                  done_q;
	logic [SPEED_BITS-2:0] mag_q;
	logic [PB-1:0]         prod_q;

	logic [srp_pkg::STEP_DIV_BITS-1:0] step_div;
	logic [PB-1:0]                     dvd;
	logic [D-1:0]                      dvs;
	logic [srp_pkg::ITER_BITS-1:0]     its;
	logic                              div_done;
	logic [PB-1:0]                     quo;

	assign step_div = srp_pkg::STEP_DIV_BITS'(steps_per_rev) << microstep_shift;
	assign dvd = sel2_q ? prod_q : (PB'(clock_x30) << srp_pkg::MUL_SHIFT);
	assign dvs = sel2_q ? D'(mag_q) : D'(step_div);
	assign its = sel2_q ? srp_pkg::DIV2_ITERS : srp_pkg::DIV1_ITERS;

	srp_div #(.N(PB), .D(D)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (go_q),
		.dividend (dvd),
		.divisor  (dvs),
		.iters    (its),
		.done     (div_done),
		.quo      (quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= S_IDLE;
			go_q   <= 1'b0;
			sel2_q <= 1'b0;
			done_q <= 1'b0;
			mag_q  <= '0;
			prod_q <= '0;
		end else begin
			go_q   <= 1'b0;
			done_q <= 1'b0;
			case (st_q)
				S_IDLE: begin
					if (start) begin
						mag_q  <= mag;
						sel2_q <= 1'b0;
						go_q   <= 1'b1;
						st_q   <= S_DIV1;
					end
				end
				S_DIV1: begin
					if (div_done) begin
						st_q <= S_MUL;
					end
				end
				S_MUL: begin
					prod_q <= PB'(quo[CB-1:0]) * PB'(srp_pkg::MUL_K);
					sel2_q <= 1'b1;
					go_q   <= 1'b1;
					st_q   <= S_DIV2;
				end
				S_DIV2: begin
					if (div_done) begin
						done_q <= 1'b1;
						st_q   <= S_IDLE;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	assign done   = done_q;
	assign period = (|quo[PB-1:CB]) ? '1 : quo[CB-1:0];
endmodule

// ===== hdl/stepper_speed_ramp_core.sv =====
`timescale 1ns / 1ps

// Stepper speed ramp core.
// cmd channel (valid/ready): action and signed target_in. rsp channel (valid/ready):
// one result item per cmd item with speed, direction, period, load flag, enable, run.
// cfg port: cfg_we writes cfg_data into register cfg_idx; write only while idle.
// Set target, start, stop and a tick that is stopped or lands on zero speed:
// result valid in the cycle after the item is taken.
// A tick to a nonzero speed: the result waits on the shared bit-serial divider
// (32 steps for clock_x30 / (steps << ustep), then 42 steps for the scaled period
// divided by |speed|), with a multiply by 1000 between the two divisions.
// One item in flight at a time; cmd.ready goes high when no tick is being computed
// and the result register is free or being drained in the same cycle.
// Reset: speeds and period 0, stopped, driver disabled (enable_n 1), registers at
// their defaults. A stalled rsp holds the result and blocks new items.
module stepper_speed_ramp_core #(
	parameter int SPEED_BITS = srp_pkg::SPEED_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	srp_in_if.sink                            cmd,
	srp_out_if.source                         rsp,
	input  logic                              cfg_we,
	input  logic [srp_pkg::CFG_IDX_BITS-1:0]  cfg_idx,
	input  logic [srp_pkg::CFG_DATA_BITS-1:0] cfg_data
);
	localparam int SB = SPEED_BITS;
	localparam int LW = (SB > 17) ? SB : 17;
	localparam int CW = (SB + 1 > 17) ? SB + 1 : 17;
	localparam logic signed [LW-1:0] CAP = LW'((64'd1 << (SB - 1)) - 64'd1);

	typedef enum logic {T_IDLE, T_CALC} tstate_t;

	logic [15:0]                        max_speed_q;
	logic [15:0]                        max_delta_q;
	logic                               rev_q;
	logic [srp_pkg::USTEP_BITS-1:0]     ustep_q;
	logic [srp_pkg::CLK_BITS-1:0]       clk_x30_q;
	logic [srp_pkg::STEP_BITS-1:0]      spr_q;

	tstate_t                      st_q;
	logic                         vld_q;
	logic signed [SB-1:0]         target_q;
	logic signed [SB-1:0]         actual_q;
	logic                         run_q;
	logic                         dir_q;
	logic [srp_pkg::CLK_BITS-1:0] period_q;
	logic                         load_q;
	logic                         en_n_q;

	logic                         acc;
	logic signed [LW-1:0]         req;
	logic signed [LW-1:0]         lim_raw;
	logic signed [LW-1:0]         lim;
	logic signed [LW-1:0]         clamped;
	logic signed [CW-1:0]         diff;
	logic signed [CW-1:0]         dd;
	logic signed [CW-1:0]         ns_w;
	logic signed [SB-1:0]         ns;
	logic signed [SB-1:0]         mag_w;
	logic                         ndir;
	logic                         pstart;
	logic                         pdone;
	logic [srp_pkg::CLK_BITS-1:0] pper;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_speed_q <= srp_pkg::MAX_SPEED_RST;
			max_delta_q <= srp_pkg::MAX_DELTA_RST;
			rev_q       <= 1'b0;
			ustep_q     <= '0;
			clk_x30_q   <= srp_pkg::CLK_X30_RST;
			spr_q       <= srp_pkg::STEPS_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				srp_pkg::CFG_MAX_SPEED: max_speed_q <= cfg_data[15:0];
				srp_pkg::CFG_MAX_DELTA: max_delta_q <= cfg_data[15:0];
				srp_pkg::CFG_REVERSE:   rev_q       <= cfg_data[0];
				srp_pkg::CFG_USTEP:     ustep_q     <= cfg_data[srp_pkg::USTEP_BITS-1:0];
				srp_pkg::CFG_CLK_X30:   clk_x30_q   <= cfg_data[srp_pkg::CLK_BITS-1:0];
				srp_pkg::CFG_STEPS:     spr_q       <= cfg_data[srp_pkg::STEP_BITS-1:0];
				default: ;
			endcase
		end
	end

	// target clamp
	assign req     = LW'(cmd.target_in);
	assign lim_raw = $signed(LW'(max_speed_q));
	assign lim     = (lim_raw > CAP) ? CAP : lim_raw;
	assign clamped = (req > lim) ? lim : ((req < -lim) ? -lim : req);

	// ramp step
	assign diff = CW'(target_q) - CW'(actual_q);
	assign dd   = $signed(CW'(max_delta_q));
	assign ns_w = (diff > dd) ? CW'(actual_q) + dd :
		((diff < -dd) ? CW'(actual_q) - dd : CW'(target_q));
	assign ns    = SB'(ns_w);
	assign mag_w = ns[SB-1] ? -ns : ns;
	assign ndir  = rev_q ? ns[SB-1] : (!ns[SB-1] && (ns != '0));

	assign acc    = cmd.valid && cmd.ready;
	assign pstart = acc && (cmd.action == srp_pkg::ACT_TICK) && run_q && (ns != '0);

	srp_period #(.SPEED_BITS(SB)) u_period (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (pstart),
		.mag             (mag_w[SB-2:0]),
		.clock_x30       (clk_x30_q),
		.steps_per_rev   (spr_q),
		.microstep_shift (ustep_q),
		.done            (pdone),
		.period          (pper)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= T_IDLE;
			vld_q    <= 1'b0;
			target_q <= '0;
			actual_q <= '0;
			run_q    <= 1'b0;
			dir_q    <= 1'b0;
			period_q <= '0;
			load_q   <= 1'b0;
			en_n_q   <= 1'b1;
		end else begin
			if (rsp.valid && rsp.ready) begin
				vld_q <= 1'b0;
			end
			case (st_q)
				T_IDLE: begin
					if (acc) begin
						load_q <= 1'b0;
						vld_q  <= 1'b1;
						case (cmd.action)
							srp_pkg::ACT_SET: begin
								target_q <= SB'(clamped);
							end
							srp_pkg::ACT_TICK: begin
								if (run_q) begin
									actual_q <= ns;
									dir_q    <= ndir;
									if (ns != '0) begin
										vld_q <= 1'b0;
										st_q  <= T_CALC;
									end
								end
							end
							srp_pkg::ACT_START: begin
								en_n_q   <= 1'b0;
								target_q <= '0;
								actual_q <= '0;
								run_q    <= 1'b1;
							end
							default: begin
								en_n_q   <= 1'b1;
								target_q <= '0;
								actual_q <= '0;
								run_q    <= 1'b0;
							end
						endcase
					end
				end
				T_CALC: begin
					if (pdone) begin
						period_q <= pper;
						load_q   <= 1'b1;
						vld_q    <= 1'b1;
						st_q     <= T_IDLE;
					end
				end
				default: st_q <= T_IDLE;
			endcase
		end
	end

	assign cmd.ready       = (st_q == T_IDLE) && (!vld_q || rsp.ready);
	assign rsp.valid       = vld_q;
	assign rsp.speed_now   = actual_q;
	assign rsp.dir_pin     = dir_q;
	assign rsp.step_period = period_q;
	assign rsp.period_load = load_q;
	assign rsp.enable_n    = en_n_q;
	assign rsp.running     = run_q;

`ifndef SYNTHESIS
	a_acc_result: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> (vld_q || st_q == T_CALC))
		else $error("item taken without a pending result");
	a_calc_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == T_CALC) |-> !vld_q)
		else $error("result register busy during period computation");
	a_done_calc: assert property (@(posedge clk) disable iff (!arst_n)
		pdone |-> (st_q == T_CALC))
		else $error("period unit finished with no tick in flight");
	a_load_speed: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_q && load_q) |-> (actual_q != '0 && run_q))
		else $error("period loaded at zero speed or while stopped");
`endif
endmodule
